// ----- sv/pse_pkg.sv -----
// shared types and constants for the pole sum spectral evaluator
package pse_pkg;

   // field and datapath widths
   localparam int WORD_W    = 32;
   localparam int ETA_W     = 31;
   localparam int OPND_W    = 33;
   localparam int PROD_W    = 66;
   localparam int NSUM_W    = 65;
   localparam int DEN_W     = 66;
   localparam int NUM_W     = 98;
   localparam int ACC_W     = 48;
   localparam int QUO_W     = 48;
   localparam int DIV_STEPS = 48;
   localparam int CNT_W     = 6;

   // saturation limits
   localparam logic signed [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [WORD_W-1:0] OUT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] OUT_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic [CNT_W-1:0]         DIV_LAST = CNT_W'(DIV_STEPS - 1);

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_M5,
      ST_M6,
      ST_M7,
      ST_M8,
      ST_M9,
      ST_M10,
      ST_M11,
      ST_CHECK,
      ST_DIVIDE,
      ST_ADD,
      ST_FINISH
   } state_type;

   // multiplier operand pairs
   typedef enum logic [3:0] {
      MUL_UR_VR,
      MUL_UI_VI,
      MUL_UR_VI,
      MUL_UI_VR,
      MUL_DRE_DRE,
      MUL_DIM_DIM,
      MUL_NLIM_DRE,
      MUL_NHIM_DRE,
      MUL_NLRE_DIM,
      MUL_NHRE_DIM
   } mul_sel_type;

   // wide sum register operations
   typedef enum logic [1:0] {
      SUM_HOLD,
      SUM_LOAD,
      SUM_ADD
   } sum_op_type;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      sum_op_type  sum_op;
      logic        sum_neg;
      logic        sum_shift;
      logic        save_nre;
      logic        save_nim;
      logic        save_den;
      logic        div_init;
      logic        div_step;
      logic        term_add;
      logic        mark_zero;
      logic        emit;
   } cmd_type;

   // status from the datapath to the sequencer
   typedef struct packed {
      logic den_zero;
      logic big;
      logic last;
      logic out_free;
   } status_type;

endpackage

// ----- sv/pse_ctrl.sv -----
// sequencer for one term: multiply schedule, divide loop and result hand-off
module pse_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pse_pkg::status_type status,
   output pse_pkg::cmd_type    cmd
);

   pse_pkg::state_type          state_ff, state_in;
   logic [pse_pkg::CNT_W-1:0]   cnt_ff, cnt_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pse_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         pse_pkg::ST_IDLE:   if (req_valid) state_in = pse_pkg::ST_M1;
         pse_pkg::ST_M1:     state_in = pse_pkg::ST_M2;
         pse_pkg::ST_M2:     state_in = pse_pkg::ST_M3;
         pse_pkg::ST_M3:     state_in = pse_pkg::ST_M4;
         pse_pkg::ST_M4:     state_in = pse_pkg::ST_M5;
         pse_pkg::ST_M5:     state_in = pse_pkg::ST_M6;
         pse_pkg::ST_M6:     state_in = pse_pkg::ST_M7;
         pse_pkg::ST_M7:     state_in = pse_pkg::ST_M8;
         pse_pkg::ST_M8:     state_in = pse_pkg::ST_M9;
         pse_pkg::ST_M9:     state_in = pse_pkg::ST_M10;
         pse_pkg::ST_M10:    state_in = pse_pkg::ST_M11;
         pse_pkg::ST_M11:    state_in = pse_pkg::ST_CHECK;
         pse_pkg::ST_CHECK: begin
            cnt_in = '0;
            if (status.den_zero) begin
               state_in = pse_pkg::ST_FINISH;
            end else if (status.big) begin
               state_in = pse_pkg::ST_ADD;
            end else begin
               state_in = pse_pkg::ST_DIVIDE;
            end
         end
         pse_pkg::ST_DIVIDE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == pse_pkg::DIV_LAST) state_in = pse_pkg::ST_ADD;
         end
         pse_pkg::ST_ADD:    state_in = pse_pkg::ST_FINISH;
         pse_pkg::ST_FINISH: begin
            if (!status.last || status.out_free) state_in = pse_pkg::ST_IDLE;
         end
         default:            state_in = pse_pkg::ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd           = '0;
      cmd.mul_sel   = pse_pkg::MUL_UR_VR;
      cmd.sum_op    = pse_pkg::SUM_HOLD;
      req_stall     = 1'b1;
      case (state_ff)
         pse_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         pse_pkg::ST_M1: cmd.mul_sel = pse_pkg::MUL_UR_VR;
         pse_pkg::ST_M2: begin
            cmd.mul_sel = pse_pkg::MUL_UI_VI;
            cmd.sum_op  = pse_pkg::SUM_LOAD;
         end
         pse_pkg::ST_M3: begin
            cmd.mul_sel = pse_pkg::MUL_UR_VI;
            cmd.sum_op  = pse_pkg::SUM_ADD;
            cmd.sum_neg = 1'b1;
         end
         pse_pkg::ST_M4: begin
            cmd.mul_sel  = pse_pkg::MUL_UI_VR;
            cmd.sum_op   = pse_pkg::SUM_LOAD;
            cmd.save_nre = 1'b1;
         end
         pse_pkg::ST_M5: begin
            cmd.mul_sel = pse_pkg::MUL_DRE_DRE;
            cmd.sum_op  = pse_pkg::SUM_ADD;
         end
         pse_pkg::ST_M6: begin
            cmd.mul_sel  = pse_pkg::MUL_DIM_DIM;
            cmd.sum_op   = pse_pkg::SUM_LOAD;
            cmd.save_nim = 1'b1;
         end
         pse_pkg::ST_M7: begin
            cmd.mul_sel = pse_pkg::MUL_NLIM_DRE;
            cmd.sum_op  = pse_pkg::SUM_ADD;
         end
         pse_pkg::ST_M8: begin
            cmd.mul_sel  = pse_pkg::MUL_NHIM_DRE;
            cmd.sum_op   = pse_pkg::SUM_LOAD;
            cmd.save_den = 1'b1;
         end
         pse_pkg::ST_M9: begin
            cmd.mul_sel   = pse_pkg::MUL_NLRE_DIM;
            cmd.sum_op    = pse_pkg::SUM_ADD;
            cmd.sum_shift = 1'b1;
         end
         pse_pkg::ST_M10: begin
            cmd.mul_sel = pse_pkg::MUL_NHRE_DIM;
            cmd.sum_op  = pse_pkg::SUM_ADD;
            cmd.sum_neg = 1'b1;
         end
         pse_pkg::ST_M11: begin
            cmd.sum_op    = pse_pkg::SUM_ADD;
            cmd.sum_neg   = 1'b1;
            cmd.sum_shift = 1'b1;
         end
         pse_pkg::ST_CHECK: begin
            cmd.div_init  = 1'b1;
            cmd.mark_zero = status.den_zero;
         end
         pse_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
         pse_pkg::ST_ADD:    cmd.term_add = 1'b1;
         pse_pkg::ST_FINISH: cmd.emit = status.last && status.out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- sv/pse_datapath.sv -----
// term datapath: operand registers, shared multiplier, wide sum, divider, accumulator
module pse_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pse_pkg::cmd_type                      cmd,
   output pse_pkg::status_type                   status,
   input  logic [pse_pkg::ETA_W-1:0]             broadening,
   input  logic signed [pse_pkg::WORD_W-1:0]     req_pole_real,
   input  logic signed [pse_pkg::WORD_W-1:0]     req_pole_imag,
   input  logic signed [pse_pkg::WORD_W-1:0]     req_left_weight_real,
   input  logic signed [pse_pkg::WORD_W-1:0]     req_left_weight_imag,
   input  logic signed [pse_pkg::WORD_W-1:0]     req_right_weight_real,
   input  logic signed [pse_pkg::WORD_W-1:0]     req_right_weight_imag,
   input  logic signed [pse_pkg::WORD_W-1:0]     req_frequency,
   input  logic                                  req_last_term,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [pse_pkg::WORD_W-1:0]     rsp_sum_imag,
   output logic                                  rsp_saturated,
   output logic                                  rsp_zero_pole_seen
);

   // captured term
   logic signed [pse_pkg::WORD_W-1:0] ur_ff, ui_ff, vr_ff, vi_ff;
   logic signed [pse_pkg::OPND_W-1:0] d_re_ff, d_im_ff;
   logic                              last_ff;

   // multiplier and wide sum
   logic signed [pse_pkg::OPND_W-1:0] mul_a, mul_b;
   logic signed [pse_pkg::PROD_W-1:0] prod_ff;
   logic signed [pse_pkg::NUM_W-1:0]  sum_ff;
   logic signed [pse_pkg::NUM_W-1:0]  sum_opnd, sum_shifted;
   logic signed [pse_pkg::NSUM_W-1:0] n_re_ff, n_im_ff;
   logic [pse_pkg::DEN_W-1:0]         den_ff;

   // divider
   logic [pse_pkg::NUM_W-1:0]   num_mag;
   logic                        num_neg, big;
   logic                        neg_ff, big_ff;
   logic [pse_pkg::DEN_W-1:0]   rem_ff;
   logic [pse_pkg::QUO_W-1:0]   quo_ff;
   logic [pse_pkg::DEN_W+1:0]   div_diff;
   logic                        div_ge;

   // accumulator and flags
   logic signed [pse_pkg::ACC_W-1:0] accum_ff, term;
   logic signed [pse_pkg::ACC_W:0]   accum_sum;
   logic                             sat_flag_ff, zero_flag_ff;
   logic                             pos_clip, neg_clip, term_clip, sum_clip;

   // result register
   logic                              rsp_valid_ff;
   logic signed [pse_pkg::WORD_W-1:0] rsp_sum_ff;
   logic                              rsp_sat_ff, rsp_zero_ff;
   logic signed [pse_pkg::WORD_W-1:0] out_sum;
   logic                              out_fits;

   // term capture with the two denominator parts
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ur_ff   <= req_left_weight_real;
         ui_ff   <= req_left_weight_imag;
         vr_ff   <= req_right_weight_real;
         vi_ff   <= req_right_weight_imag;
         last_ff <= req_last_term;
         d_re_ff <= {req_frequency[pse_pkg::WORD_W-1], req_frequency}
                  + {req_pole_real[pse_pkg::WORD_W-1], req_pole_real};
         d_im_ff <= $signed({2'b00, broadening})
                  + {req_pole_imag[pse_pkg::WORD_W-1], req_pole_imag};
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         pse_pkg::MUL_UR_VR: begin
            mul_a = {ur_ff[pse_pkg::WORD_W-1], ur_ff};
            mul_b = {vr_ff[pse_pkg::WORD_W-1], vr_ff};
         end
         pse_pkg::MUL_UI_VI: begin
            mul_a = {ui_ff[pse_pkg::WORD_W-1], ui_ff};
            mul_b = {vi_ff[pse_pkg::WORD_W-1], vi_ff};
         end
         pse_pkg::MUL_UR_VI: begin
            mul_a = {ur_ff[pse_pkg::WORD_W-1], ur_ff};
            mul_b = {vi_ff[pse_pkg::WORD_W-1], vi_ff};
         end
         pse_pkg::MUL_UI_VR: begin
            mul_a = {ui_ff[pse_pkg::WORD_W-1], ui_ff};
            mul_b = {vr_ff[pse_pkg::WORD_W-1], vr_ff};
         end
         pse_pkg::MUL_DRE_DRE: begin
            mul_a = d_re_ff;
            mul_b = d_re_ff;
         end
         pse_pkg::MUL_DIM_DIM: begin
            mul_a = d_im_ff;
            mul_b = d_im_ff;
         end
         pse_pkg::MUL_NLIM_DRE: begin
            mul_a = {1'b0, n_im_ff[pse_pkg::WORD_W-1:0]};
            mul_b = d_re_ff;
         end
         pse_pkg::MUL_NHIM_DRE: begin
            mul_a = n_im_ff[pse_pkg::NSUM_W-1:pse_pkg::WORD_W];
            mul_b = d_re_ff;
         end
         pse_pkg::MUL_NLRE_DIM: begin
            mul_a = {1'b0, n_re_ff[pse_pkg::WORD_W-1:0]};
            mul_b = d_im_ff;
         end
         pse_pkg::MUL_NHRE_DIM: begin
            mul_a = n_re_ff[pse_pkg::NSUM_W-1:pse_pkg::WORD_W];
            mul_b = d_im_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // product register
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // product aligned and signed for the wide sum
   always_comb begin
      if (cmd.sum_shift) begin
         sum_shifted = {prod_ff, {pse_pkg::WORD_W{1'b0}}};
      end else begin
         sum_shifted = {{(pse_pkg::NUM_W-pse_pkg::PROD_W){prod_ff[pse_pkg::PROD_W-1]}},
                        prod_ff};
      end
      sum_opnd = cmd.sum_neg ? -sum_shifted : sum_shifted;
   end

   // wide sum and partial result saves
   always_ff @(posedge clock) begin
      case (cmd.sum_op)
         pse_pkg::SUM_LOAD: sum_ff <= sum_opnd;
         pse_pkg::SUM_ADD:  sum_ff <= sum_ff + sum_opnd;
         default:           sum_ff <= sum_ff;
      endcase
      if (cmd.save_nre) n_re_ff <= sum_ff[pse_pkg::NSUM_W-1:0];
      if (cmd.save_nim) n_im_ff <= sum_ff[pse_pkg::NSUM_W-1:0];
      if (cmd.save_den) den_ff  <= sum_ff[pse_pkg::DEN_W-1:0];
   end

   // numerator magnitude and quotient range check
   always_comb begin
      num_neg = sum_ff[pse_pkg::NUM_W-1];
      num_mag = num_neg ? (~sum_ff + 1'b1) : sum_ff;
      big     = {{(pse_pkg::DEN_W-(pse_pkg::NUM_W-pse_pkg::QUO_W)){1'b0}},
                 num_mag[pse_pkg::NUM_W-1:pse_pkg::QUO_W]} >= den_ff;
   end

   // one restoring divide step
   always_comb begin
      div_diff = {1'b0, rem_ff, quo_ff[pse_pkg::QUO_W-1]} - {2'b00, den_ff};
      div_ge   = !div_diff[pse_pkg::DEN_W+1];
   end

   // divider registers
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         neg_ff <= num_neg;
         big_ff <= big;
         rem_ff <= {{(pse_pkg::DEN_W-(pse_pkg::NUM_W-pse_pkg::QUO_W)){1'b0}},
                    num_mag[pse_pkg::NUM_W-1:pse_pkg::QUO_W]};
         quo_ff <= num_mag[pse_pkg::QUO_W-1:0];
      end else if (cmd.div_step) begin
         if (div_ge) begin
            rem_ff <= div_diff[pse_pkg::DEN_W-1:0];
         end else begin
            rem_ff <= {rem_ff[pse_pkg::DEN_W-2:0], quo_ff[pse_pkg::QUO_W-1]};
         end
         quo_ff <= {quo_ff[pse_pkg::QUO_W-2:0], div_ge};
      end
   end

   // signed and clipped term, then saturating add
   always_comb begin
      pos_clip  = !neg_ff && (big_ff || quo_ff[pse_pkg::QUO_W-1]);
      neg_clip  = neg_ff && (big_ff || (quo_ff[pse_pkg::QUO_W-1]
                                        && (|quo_ff[pse_pkg::QUO_W-2:0])));
      term_clip = pos_clip || neg_clip;
      if (pos_clip) begin
         term = pse_pkg::ACC_MAX;
      end else if (neg_clip) begin
         term = pse_pkg::ACC_MIN;
      end else if (neg_ff) begin
         term = -$signed(quo_ff);
      end else begin
         term = $signed(quo_ff);
      end
      accum_sum = {accum_ff[pse_pkg::ACC_W-1], accum_ff} + {term[pse_pkg::ACC_W-1], term};
      sum_clip  = accum_sum[pse_pkg::ACC_W] != accum_sum[pse_pkg::ACC_W-1];
   end

   // result clipped to the word range
   always_comb begin
      out_fits = (&accum_ff[pse_pkg::ACC_W-1:pse_pkg::WORD_W-1])
              || !(|accum_ff[pse_pkg::ACC_W-1:pse_pkg::WORD_W-1]);
      if (out_fits) begin
         out_sum = accum_ff[pse_pkg::WORD_W-1:0];
      end else if (accum_ff[pse_pkg::ACC_W-1]) begin
         out_sum = pse_pkg::OUT_MIN;
      end else begin
         out_sum = pse_pkg::OUT_MAX;
      end
   end

   // accumulator and status flags
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff     <= '0;
         sat_flag_ff  <= 1'b0;
         zero_flag_ff <= 1'b0;
      end else if (cmd.emit) begin
         accum_ff     <= '0;
         sat_flag_ff  <= 1'b0;
         zero_flag_ff <= 1'b0;
      end else begin
         if (cmd.term_add) begin
            if (sum_clip) begin
               accum_ff <= accum_sum[pse_pkg::ACC_W] ? pse_pkg::ACC_MIN : pse_pkg::ACC_MAX;
            end else begin
               accum_ff <= accum_sum[pse_pkg::ACC_W-1:0];
            end
            if (term_clip || sum_clip) sat_flag_ff <= 1'b1;
         end
         if (cmd.mark_zero) zero_flag_ff <= 1'b1;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_sum_ff  <= out_sum;
         rsp_sat_ff  <= sat_flag_ff || !out_fits;
         rsp_zero_ff <= zero_flag_ff;
      end
   end

   // status back to the sequencer
   always_comb begin
      status.den_zero = den_ff == '0;
      status.big      = big;
      status.last     = last_ff;
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sum_imag       = rsp_sum_ff;
   assign rsp_saturated      = rsp_sat_ff;
   assign rsp_zero_pole_seen = rsp_zero_ff;

endmodule

// ----- sv/pole_sum_spectral_eval_top.sv -----
// top level of the pole sum spectral evaluator
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  pole, weights, frequency, last_term
//   rsp      out        rsp_valid/rsp_stall  sum_imag, saturated, zero_pole_seen
//   csr      in         csr_valid/csr_ready  broadening (eta)
//
// a term runs from one acceptance to the next: accept, M1 to M11 on the shared 33x33
// multiplier, one range check, 48 restoring divide steps, one accumulate, one finish;
// a zero denominator skips the divide and accumulate, a clipped quotient the divide.
// reset is synchronous, clears the accumulator and flags and loads broadening with 0.1.
// a last term waits in its finish cycle while the result word register is full and
// stalled; otherwise the result register frees the input side at once.
module pole_sum_spectral_eval_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [pse_pkg::WORD_W-1:0]     req_pole_real,
   input  logic signed [pse_pkg::WORD_W-1:0]     req_pole_imag,
   input  logic signed [pse_pkg::WORD_W-1:0]     req_left_weight_real,
   input  logic signed [pse_pkg::WORD_W-1:0]     req_left_weight_imag,
   input  logic signed [pse_pkg::WORD_W-1:0]     req_right_weight_real,
   input  logic signed [pse_pkg::WORD_W-1:0]     req_right_weight_imag,
   input  logic signed [pse_pkg::WORD_W-1:0]     req_frequency,
   input  logic                                  req_last_term,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [pse_pkg::WORD_W-1:0]     rsp_sum_imag,
   output logic                                  rsp_saturated,
   output logic                                  rsp_zero_pole_seen,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pse_pkg::ETA_W-1:0]             csr_broadening
);

   // eta reset value is 0.1 rounded in the chosen fixed point format
   localparam logic [pse_pkg::ETA_W-1:0] BROADENING_RESET =
      pse_pkg::ETA_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

   logic [pse_pkg::ETA_W-1:0] broadening_ff;
   pse_pkg::cmd_type          cmd;
   pse_pkg::status_type       status;

   // broadening register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         broadening_ff <= BROADENING_RESET;
      end else if (csr_valid && csr_ready) begin
         broadening_ff <= csr_broadening;
      end
   end

   // sequencer
   pse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   pse_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .broadening            (broadening_ff),
      .req_pole_real         (req_pole_real),
      .req_pole_imag         (req_pole_imag),
      .req_left_weight_real  (req_left_weight_real),
      .req_left_weight_imag  (req_left_weight_imag),
      .req_right_weight_real (req_right_weight_real),
      .req_right_weight_imag (req_right_weight_imag),
      .req_frequency         (req_frequency),
      .req_last_term         (req_last_term),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_sum_imag          (rsp_sum_imag),
      .rsp_saturated         (rsp_saturated),
      .rsp_zero_pole_seen    (rsp_zero_pole_seen)
   );

endmodule
